// ----- rtl/core/srad_pkg.sv -----
// ----------------------------------------------------------------------------
// srad_pkg: shared types and constants of the shelf rectangle allocator
// Sizes of the shelf row, coordinate widths, register indexes and the control
// and request bundles that the allocator broadcasts to its shelf cells.
// ----------------------------------------------------------------------------
package srad_pkg;

  localparam int SHELF_SLOTS = 64;
  localparam int MAX_SIDE    = 4096;

  localparam int COORD_W = 13;
  localparam int PAD_W   = 4;
  localparam int STEP_W  = COORD_W + 1;
  localparam int CNT_W   = $clog2(SHELF_SLOTS + 1);
  localparam int CFG_W   = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] CFG_PAD_PIXELS   = 2'd2;

  // Sequencing strobes for one shelf cell
  typedef struct packed {
    logic eval;    // register this shelf's fit flag
    logic pick;    // register the first-fit grant from the claim chain
    logic commit;  // advance the granted cursor
    logic open;    // shelf has been created
    logic alloc;   // write this slot as a new shelf
  } cell_ctl_t;

  // Request data broadcast along the row
  typedef struct packed {
    logic [STEP_W-1:0]  step;        // rect width plus padding
    logic [COORD_W-1:0] height;      // rect height
    logic [COORD_W-1:0] width_lim;   // clamped atlas width
    logic [COORD_W-1:0] new_top;     // top of a new shelf
    logic [COORD_W-1:0] new_cursor;  // cursor of a new shelf
  } cell_req_t;

endpackage

// ----- rtl/core/srad_shelf_cell.sv -----
// ----------------------------------------------------------------------------
// srad_shelf_cell: one shelf of the allocator
// Holds cursor, top and height of one shelf, evaluates the fit of the current
// request and forwards the first-fit claim to its neighbor.
// ----------------------------------------------------------------------------
module srad_shelf_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srad_pkg::cell_ctl_t         ctl_i,
  input  srad_pkg::cell_req_t         req_i,
  input  logic                        claim_i,
  output logic                        claim_o,
  output logic                        grant_o,
  output logic [srad_pkg::COORD_W-1:0] hit_x_o,
  output logic [srad_pkg::COORD_W-1:0] hit_y_o
);

  logic [srad_pkg::COORD_W-1:0] cursor_q;
  logic [srad_pkg::COORD_W-1:0] top_q;
  logic [srad_pkg::COORD_W-1:0] tall_q;
  logic [srad_pkg::STEP_W:0]    reach;
  logic                         fit_d;
  logic                         fit_q;
  logic                         grant_q;

  // Right edge of the request if it went on this shelf
  assign reach = {2'b00, cursor_q} + {1'b0, req_i.step};

  assign fit_d = ctl_i.open && (req_i.height <= tall_q) &&
                 (reach <= {2'b00, req_i.width_lim});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q   <= 1'b0;
      grant_q <= 1'b0;
    end else begin
      if (ctl_i.eval) begin
        fit_q   <= fit_d;
        grant_q <= 1'b0;
      end
      if (ctl_i.pick) begin
        grant_q <= fit_q & ~claim_i;
      end
    end
  end

  // Shelf contents: undefined until the slot is allocated
  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) begin
      cursor_q <= req_i.new_cursor;
      top_q    <= req_i.new_top;
      tall_q   <= req_i.height;
    end else if (ctl_i.commit && grant_q) begin
      cursor_q <= reach[srad_pkg::COORD_W-1:0];
    end
  end

  assign claim_o = claim_i | fit_q;
  assign grant_o = grant_q;
  assign hit_x_o = grant_q ? cursor_q : '0;
  assign hit_y_o = grant_q ? top_q : '0;

endmodule

// ----- rtl/core/shelf_rectangle_allocator.sv -----
// ----------------------------------------------------------------------------
// shelf_rectangle_allocator: first-fit shelf packing of rectangles
// A row of shelf cells, one per shelf slot, finds the first shelf in creation
// order with room for the request; else a new shelf opens at the top or placement fails.
// ----------------------------------------------------------------------------
// Sequencing: an accepted request passes the fit evaluate, claim chain pick
//   and commit steps over the shelf cell row before its result is registered;
//   a new request is taken only once the last one has committed, and a
//   stalled result holds commit.
// Reset: the atlas is empty at once (no shelves, top at 0); no clearing pass.
// ----------------------------------------------------------------------------
module shelf_rectangle_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [srad_pkg::CFG_W-1:0]    cfg_idx_i,
  input  logic [srad_pkg::COORD_W-1:0]  cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srad_pkg::COORD_W-1:0]  rect_width_i,
  input  logic [srad_pkg::COORD_W-1:0]  rect_height_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          placed_o,
  output logic [srad_pkg::COORD_W-1:0]  pos_x_o,
  output logic [srad_pkg::COORD_W-1:0]  pos_y_o
);

  localparam int SLOTS = srad_pkg::SHELF_SLOTS;
  localparam int CW    = srad_pkg::COORD_W;
  localparam logic [CW-1:0] SIDE_LIM = CW'(srad_pkg::MAX_SIDE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PICK,
    ST_COMMIT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CW-1:0]                atlas_width_q;
  logic [CW-1:0]                atlas_height_q;
  logic [srad_pkg::PAD_W-1:0]   pad_pixels_q;

  // Allocator state
  logic [srad_pkg::CNT_W-1:0]   shelves_used_q;
  logic [CW-1:0]                next_top_q;

  // Request being worked on
  logic [CW-1:0]                width_q;
  logic [CW-1:0]                height_q;

  // Result register
  logic                         out_valid_q;
  logic                         placed_q;
  logic [CW-1:0]                pos_x_q;
  logic [CW-1:0]                pos_y_q;

  logic                         in_fire;
  logic                         commit_fire;
  logic [CW-1:0]                aw_clamped;
  logic [CW-1:0]                ah_clamped;
  logic [srad_pkg::STEP_W-1:0]  step;
  logic [CW+1:0]                shelf_end;
  logic                         slot_free;
  logic                         room_new;
  logic                         open_new;
  logic                         found;
  logic [CW-1:0]                fit_x;
  logic [CW-1:0]                fit_y;

  srad_pkg::cell_req_t          req;
  srad_pkg::cell_ctl_t          cell_ctl [SLOTS];
  logic [SLOTS:0]               claim;
  logic [SLOTS-1:0]             grant;
  logic [CW-1:0]                hit_x [SLOTS];
  logic [CW-1:0]                hit_y [SLOTS];

  assign in_fire     = in_valid_i && in_ready_o;
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Clamp oversized atlas sides to the largest supported side
  assign aw_clamped = (atlas_width_q > SIDE_LIM) ? SIDE_LIM : atlas_width_q;
  assign ah_clamped = (atlas_height_q > SIDE_LIM) ? SIDE_LIM : atlas_height_q;

  assign step = {1'b0, width_q} + {{(srad_pkg::STEP_W - srad_pkg::PAD_W){1'b0}}, pad_pixels_q};

  // New shelf: needs a free slot and room below the running top
  assign shelf_end = {2'b00, next_top_q} + {2'b00, height_q} +
                     {{(CW + 2 - srad_pkg::PAD_W){1'b0}}, pad_pixels_q};
  assign slot_free = shelves_used_q < srad_pkg::CNT_W'(SLOTS);
  assign room_new  = shelf_end <= {2'b00, ah_clamped};
  assign found     = |grant;
  assign open_new  = !found && slot_free && room_new;

  always_comb begin
    req.step       = step;
    req.height     = height_q;
    req.width_lim  = aw_clamped;
    req.new_top    = next_top_q;
    // Wide rectangles saturate the new shelf's cursor
    req.new_cursor = step[srad_pkg::STEP_W-1] ? srad_pkg::COORD_MAX : step[CW-1:0];
  end

  // Row of shelf cells; the claim chain runs from the oldest shelf upward
  assign claim[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].eval   = (state_q == ST_EVAL);
      cell_ctl[i].pick   = (state_q == ST_PICK);
      cell_ctl[i].commit = commit_fire;
      cell_ctl[i].open   = srad_pkg::CNT_W'(i) < shelves_used_q;
      cell_ctl[i].alloc  = commit_fire && open_new &&
                           (shelves_used_q == srad_pkg::CNT_W'(i));
    end

    srad_shelf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl[i]),
      .req_i   (req),
      .claim_i (claim[i]),
      .claim_o (claim[i+1]),
      .grant_o (grant[i]),
      .hit_x_o (hit_x[i]),
      .hit_y_o (hit_y[i])
    );
  end

  // Merge the granted shelf's position; at most one cell drives nonzero
  always_comb begin
    fit_x = '0;
    fit_y = '0;
    for (int k = 0; k < SLOTS; k++) begin
      fit_x = fit_x | hit_x[k];
      fit_y = fit_y | hit_y[k];
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q  <= SIDE_LIM;
      atlas_height_q <= SIDE_LIM;
      pad_pixels_q   <= srad_pkg::PAD_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srad_pkg::CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i;
        srad_pkg::CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_data_i;
        srad_pkg::CFG_PAD_PIXELS:   pad_pixels_q   <= cfg_data_i[srad_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      width_q  <= rect_width_i;
      height_q <= rect_height_i;
    end
  end

  // Sequencer, allocator state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      shelves_used_q <= '0;
      next_top_q     <= '0;
      out_valid_q    <= 1'b0;
      placed_q       <= 1'b0;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
    end else begin
      // drop the result once taken, unless a new one replaces it now
      if (out_valid_q && out_ready_i && !commit_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit_fire) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            if (found) begin
              placed_q <= 1'b1;
              pos_x_q  <= fit_x;
              pos_y_q  <= fit_y;
            end else if (open_new) begin
              placed_q       <= 1'b1;
              pos_x_q        <= '0;
              pos_y_q        <= next_top_q;
              shelves_used_q <= shelves_used_q + srad_pkg::CNT_W'(1);
              next_top_q     <= shelf_end[CW-1:0];
            end else begin
              // atlas full: report failure, leave state untouched
              placed_q <= 1'b0;
              pos_x_q  <= '0;
              pos_y_q  <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign placed_o    = placed_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

`ifndef SYNTHESIS
  a_grant_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(grant))
    else $error("more than one shelf granted");

  a_chain_matches_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> (claim[SLOTS] == found))
    else $error("claim chain tail disagrees with grants");

  a_shelf_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shelves_used_q <= srad_pkg::CNT_W'(SLOTS))
    else $error("shelf count beyond slot count");

  a_shelf_count_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |=> (shelves_used_q == $past(shelves_used_q)) ||
                    (shelves_used_q == $past(shelves_used_q) + srad_pkg::CNT_W'(1)))
    else $error("shelf count changed by more than one");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second request taken while one is in flight");
`endif

endmodule
